// ===== sv/iswoc_pkg.sv =====
// Shared types and constants for the IMU stillness-gated offset calibrator.
// No dependencies; used by imu_still_wait_offset_calibrator.
`default_nettype none

package iswoc_pkg;

	// sample and accumulator geometry
	localparam int AXES        = 6;
	localparam int ACCEL_AXES  = 3;
	localparam int SAMPLE_BITS = 16;
	localparam int SUM_BITS    = 24;
	localparam int AVG_SAMPLES = 100;

	// truncating divide by AVG_SAMPLES: (|sum| * RECIP_MUL) >> RECIP_SHIFT
	// exact for |sum| <= 2^23 and any AVG_SAMPLES in 1..255
	localparam int RECIP_SHIFT = 31;
	localparam int RECIP_BITS  = 32;
	localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
	localparam logic [RECIP_BITS-1:0] RECIP_MUL =
		RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));

	// configuration register indexes
	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STILL_THRESHOLD  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STILL_RUN_LENGTH = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GRAVITY_REF      = 2'd2;

	// configuration reset values
	localparam logic [15:0] THRESHOLD_RESET  = 16'd400;
	localparam logic [7:0]  RUN_LENGTH_RESET = 8'd100;
	localparam logic [14:0] GRAVITY_RESET    = 15'd16384;

	// calibration phase
	typedef enum logic [1:0] {
		PH_WAIT = 2'd0,
		PH_AVG  = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [SUM_BITS-1:0]    sum_t;

endpackage

`default_nettype wire

// ===== sv/imu_still_wait_offset_calibrator.sv =====
// IMU bias calibrator: stillness detection, averaging and offset correction.
// Depends on iswoc_pkg for types, constants and the phase encoding.
//
// Each item is one six-axis sample; each produces one corrected result item.
// After reset the block waits for still_run_length consecutive samples whose
// accel change on every axis is below still_threshold (the first sample only
// primes the previous-accel store), then sums the next AVG_SAMPLES samples
// (accel z less gravity_ref) and divides by AVG_SAMPLES, truncating toward
// zero, to give six offsets. Results are the sample minus the offsets (zero
// until calibrated), wrapped to 16 bits, with the phase after that item; the
// item that finishes averaging is already corrected. Throughput is one item
// per cycle while results are taken; each item passes through the input
// register, two delay stages that cover the registered reciprocal multiply
// of the frozen sums, and the result register. The whole pipeline stalls
// while a result waits to be taken. Configuration writes are always accepted
// and should be made only while the block is idle.
`default_nettype none

module imu_still_wait_offset_calibrator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// sample channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic signed [15:0] accel_x_raw,
	input  wire logic signed [15:0] accel_y_raw,
	input  wire logic signed [15:0] accel_z_raw,
	input  wire logic signed [15:0] gyro_x_raw,
	input  wire logic signed [15:0] gyro_y_raw,
	input  wire logic signed [15:0] gyro_z_raw,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [15:0] accel_x_out,
	output logic signed [15:0] accel_y_out,
	output logic signed [15:0] accel_z_out,
	output logic signed [15:0] gyro_x_out,
	output logic signed [15:0] gyro_y_out,
	output logic signed [15:0] gyro_z_out,
	output logic [1:0]       calib_phase,
	output logic             calibrated
);

	localparam int AXES = iswoc_pkg::AXES;
	localparam int ACC  = iswoc_pkg::ACCEL_AXES;
	localparam int SB   = iswoc_pkg::SAMPLE_BITS;
	localparam int SUMB = iswoc_pkg::SUM_BITS;
	localparam int PB   = iswoc_pkg::PROD_BITS;
	localparam int RS   = iswoc_pkg::RECIP_SHIFT;

	// configuration registers
	logic [15:0] still_threshold_q;
	logic [7:0]  still_run_length_q;
	logic [14:0] gravity_ref_q;

	// calibration state
	iswoc_pkg::phase_t phase_q, phase_n;
	logic              prev_valid_q, prev_valid_n;
	iswoc_pkg::sample_t prev_accel_q [ACC];
	logic [7:0]        still_count_q, still_count_n;
	logic [7:0]        avg_count_q, avg_count_n;
	iswoc_pkg::sum_t   sums_q [AXES];
	iswoc_pkg::sum_t   sums_n [AXES];

	// pipeline
	logic              adv;
	logic              valid_s1, valid_s2, valid_s3;
	iswoc_pkg::sample_t smp_s1 [AXES];
	iswoc_pkg::sample_t smp_s2 [AXES];
	iswoc_pkg::sample_t smp_s3 [AXES];
	iswoc_pkg::phase_t  phase_s2, phase_s3;

	// offset datapath
	logic [PB-1:0]      prod_q [AXES];
	logic               neg_q [AXES];
	iswoc_pkg::sample_t offset [AXES];

	// result register
	logic               res_valid_q;
	iswoc_pkg::sample_t res_q [AXES];
	iswoc_pkg::phase_t  res_phase_q;

	assign cfg_ready = 1'b1;
	assign adv       = !res_valid_q || out_ready;
	assign in_ready  = adv;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_threshold_q  <= iswoc_pkg::THRESHOLD_RESET;
			still_run_length_q <= iswoc_pkg::RUN_LENGTH_RESET;
			gravity_ref_q      <= iswoc_pkg::GRAVITY_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				iswoc_pkg::REG_STILL_THRESHOLD:  still_threshold_q  <= cfg_data;
				iswoc_pkg::REG_STILL_RUN_LENGTH: still_run_length_q <= cfg_data[7:0];
				iswoc_pkg::REG_GRAVITY_REF:      gravity_ref_q      <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// phase update for the item leaving the input register
	always_comb begin
		logic signed [SB:0] diff;
		logic [SB:0]        mag;
		logic               still;
		logic [7:0]         cnt;
		logic signed [SUMB-1:0] v;
		phase_n       = phase_q;
		prev_valid_n  = prev_valid_q;
		still_count_n = still_count_q;
		avg_count_n   = avg_count_q;
		still         = 1'b1;
		cnt           = still_count_q;
		diff          = '0;
		mag           = '0;
		v             = '0;
		for (int i = 0; i < AXES; i++) begin
			sums_n[i] = sums_q[i];
		end
		case (phase_q)
			iswoc_pkg::PH_WAIT: begin
				if (!prev_valid_q) begin
					prev_valid_n = 1'b1;
				end else begin
					// per-axis absolute accel change against the threshold
					for (int i = 0; i < ACC; i++) begin
						diff = {smp_s1[i][SB-1], smp_s1[i]}
							- {prev_accel_q[i][SB-1], prev_accel_q[i]};
						mag  = diff[SB] ? (SB+1)'(-diff) : diff;
						if (mag >= {1'b0, still_threshold_q}) begin
							still = 1'b0;
						end
					end
					if (still) begin
						cnt = (still_count_q != 8'hFF) ? still_count_q + 8'd1 : still_count_q;
						still_count_n = cnt;
						if (cnt >= still_run_length_q) begin
							phase_n     = iswoc_pkg::PH_AVG;
							avg_count_n = '0;
							for (int i = 0; i < AXES; i++) begin
								sums_n[i] = '0;
							end
						end
					end else begin
						still_count_n = '0;
					end
				end
			end
			iswoc_pkg::PH_AVG: begin
				// wrapping accumulate, gravity removed from accel z
				for (int i = 0; i < AXES; i++) begin
					v = SUMB'(smp_s1[i]);
					if (i == 2) begin
						v = v - SUMB'({1'b0, gravity_ref_q});
					end
					sums_n[i] = sums_q[i] + v;
				end
				avg_count_n = avg_count_q + 8'd1;
				if (avg_count_n >= 8'(iswoc_pkg::AVG_SAMPLES)) begin
					phase_n = iswoc_pkg::PH_DONE;
				end
			end
			default: ;
		endcase
	end

	// calibration state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= iswoc_pkg::PH_WAIT;
			prev_valid_q  <= 1'b0;
			still_count_q <= '0;
			avg_count_q   <= '0;
		end else if (adv && valid_s1) begin
			phase_q       <= phase_n;
			prev_valid_q  <= prev_valid_n;
			still_count_q <= still_count_n;
			avg_count_q   <= avg_count_n;
		end
	end

	// accumulators and previous accel, cleared or primed before first use
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			for (int i = 0; i < AXES; i++) begin
				sums_q[i] <= sums_n[i];
			end
			if (phase_q == iswoc_pkg::PH_WAIT) begin
				for (int i = 0; i < ACC; i++) begin
					prev_accel_q[i] <= smp_s1[i];
				end
			end
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			res_valid_q <= valid_s3;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			smp_s1[0] <= accel_x_raw;
			smp_s1[1] <= accel_y_raw;
			smp_s1[2] <= accel_z_raw;
			smp_s1[3] <= gyro_x_raw;
			smp_s1[4] <= gyro_y_raw;
			smp_s1[5] <= gyro_z_raw;
			for (int i = 0; i < AXES; i++) begin
				smp_s2[i] <= smp_s1[i];
				smp_s3[i] <= smp_s2[i];
				res_q[i]  <= smp_s3[i]
					- ((phase_s3 == iswoc_pkg::PH_DONE) ? offset[i] : '0);
			end
			phase_s2    <= phase_n;
			phase_s3    <= phase_s2;
			res_phase_q <= phase_s3;
		end
	end

	// reciprocal multiply of the sum magnitudes, free running;
	// the sums are frozen once averaging ends
	always_ff @(posedge clk) begin
		for (int i = 0; i < AXES; i++) begin
			neg_q[i]  <= sums_q[i][SUMB-1];
			prod_q[i] <= PB'($unsigned(sums_q[i][SUMB-1] ? -sums_q[i] : sums_q[i]))
				* PB'(iswoc_pkg::RECIP_MUL);
		end
	end

	// quotient with sign restored, kept to sample width
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			offset[i] = neg_q[i] ? SB'(-prod_q[i][RS +: SB]) : SB'(prod_q[i][RS +: SB]);
		end
	end

	// result ports
	assign out_valid   = res_valid_q;
	assign accel_x_out = res_q[0];
	assign accel_y_out = res_q[1];
	assign accel_z_out = res_q[2];
	assign gyro_x_out  = res_q[3];
	assign gyro_y_out  = res_q[4];
	assign gyro_z_out  = res_q[5];
	assign calib_phase = res_phase_q;
	assign calibrated  = (res_phase_q == iswoc_pkg::PH_DONE);

endmodule

`default_nettype wire

// ===== bench/offset_calib_checker.sv =====
`timescale 1ns / 1ps
// Result checker for imu_still_wait_offset_calibrator: shadows the register writes,
// predicts the corrected sample for each accepted item and compares results in order.
// Depends on iswoc_pkg for widths, register indexes and the phase type.
module offset_calib_checker
	import iswoc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [15:0] accel_x_raw,
	input  logic [15:0] accel_y_raw,
	input  logic [15:0] accel_z_raw,
	input  logic [15:0] gyro_x_raw,
	input  logic [15:0] gyro_y_raw,
	input  logic [15:0] gyro_z_raw,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] accel_x_out,
	input  logic [15:0] accel_y_out,
	input  logic [15:0] accel_z_out,
	input  logic [15:0] gyro_x_out,
	input  logic [15:0] gyro_y_out,
	input  logic [15:0] gyro_z_out,
	input  logic [1:0]  calib_phase,
	input  logic        calibrated,
	output int          mismatches,
	output int          outstanding
);

	typedef logic [AXES-1:0][SAMPLE_BITS-1:0] axes_t;

	typedef struct packed {
		axes_t  axis;
		phase_t ph;
		logic   cal;
	} corrected_t;

	// shadow copies of the configuration registers
	logic [15:0] thr_q;
	logic [7:0]  run_len_q;
	logic [14:0] grav_q;

	// predicted calibration state
	phase_t      cal_phase;
	logic        have_prev;
	sample_t     prev_acc [ACCEL_AXES];
	logic [7:0]  still_run;
	logic [7:0]  avg_seen;
	sum_t        axis_sum [AXES];
	sample_t     axis_off [AXES];

	corrected_t  corrected_q [$];
	corrected_t  got;
	corrected_t  want;
	int          errs;

	string axis_name [AXES] = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y", "gyro_z"};

	// advance the calibration state by one sample and queue the corrected item
	task automatic predict_corrected(input axes_t smp);
		sample_t    s [AXES];
		int         delta;
		int         v;
		logic       still;
		corrected_t res;
		for (int i = 0; i < AXES; i++)
			s[i] = sample_t'(smp[i]);
		case (cal_phase)
		PH_WAIT: begin
			if (!have_prev) begin
				have_prev = 1'b1;
			end else begin
				still = 1'b1;
				for (int i = 0; i < ACCEL_AXES; i++) begin
					delta = int'(s[i]) - int'(prev_acc[i]);
					if (delta < 0)
						delta = -delta;
					if (delta >= int'(thr_q))
						still = 1'b0;
				end
				if (still) begin
					if (still_run != 8'd255)
						still_run++;
					// run complete: averaging starts with the next sample
					if (still_run >= run_len_q) begin
						cal_phase = PH_AVG;
						avg_seen = '0;
						for (int i = 0; i < AXES; i++)
							axis_sum[i] = '0;
					end
				end else begin
					still_run = '0;
				end
			end
			for (int i = 0; i < ACCEL_AXES; i++)
				prev_acc[i] = s[i];
		end
		PH_AVG: begin
			// accumulate with 24 bit wrap, accel z relative to gravity
			for (int i = 0; i < AXES; i++) begin
				v = int'(s[i]);
				if (i == 2)
					v = v - int'(grav_q);
				axis_sum[i] = sum_t'(int'(axis_sum[i]) + v);
			end
			avg_seen++;
			if (int'(avg_seen) >= AVG_SAMPLES) begin
				// signed divide truncates toward zero
				for (int i = 0; i < AXES; i++)
					axis_off[i] = sample_t'(int'(axis_sum[i]) / AVG_SAMPLES);
				cal_phase = PH_DONE;
			end
		end
		default: begin
		end
		endcase
		for (int i = 0; i < AXES; i++)
			res.axis[i] = s[i] - axis_off[i];
		res.ph = cal_phase;
		res.cal = (cal_phase == PH_DONE);
		corrected_q.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q = THRESHOLD_RESET;
			run_len_q = RUN_LENGTH_RESET;
			grav_q = GRAVITY_RESET;
			cal_phase = PH_WAIT;
			have_prev = 1'b0;
			still_run = '0;
			avg_seen = '0;
			for (int i = 0; i < ACCEL_AXES; i++)
				prev_acc[i] = '0;
			for (int i = 0; i < AXES; i++) begin
				axis_sum[i] = '0;
				axis_off[i] = '0;
			end
			corrected_q.delete();
			errs = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			// compare an accepted result against the oldest prediction
			if (out_valid && out_ready) begin
				got.axis = {gyro_z_out, gyro_y_out, gyro_x_out,
					accel_z_out, accel_y_out, accel_x_out};
				got.ph = phase_t'(calib_phase);
				got.cal = calibrated;
				if (corrected_q.size() == 0) begin
					$display("%0t: result item with nothing expected", $time);
					errs++;
				end else begin
					want = corrected_q.pop_front();
					for (int i = 0; i < AXES; i++) begin
						if (got.axis[i] !== want.axis[i]) begin
							$display("%0t: %s_out expected %0d actual %0d", $time, axis_name[i],
								$signed(want.axis[i]), $signed(got.axis[i]));
							errs++;
						end
					end
					if (got.ph !== want.ph) begin
						$display("%0t: calib_phase expected %0d actual %0d", $time,
							want.ph, got.ph);
						errs++;
					end
					if (got.cal !== want.cal) begin
						$display("%0t: calibrated expected %0d actual %0d", $time,
							want.cal, got.cal);
						errs++;
					end
				end
			end
			// register writes, masked to register width
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_STILL_THRESHOLD:  thr_q = cfg_data;
				REG_STILL_RUN_LENGTH: run_len_q = cfg_data[7:0];
				REG_GRAVITY_REF:      grav_q = cfg_data[14:0];
				default: begin
				end
				endcase
			end
			if (in_valid && in_ready)
				predict_corrected({gyro_z_raw, gyro_y_raw, gyro_x_raw,
					accel_z_raw, accel_y_raw, accel_x_raw});
			mismatches <= errs;
			outstanding <= corrected_q.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for imu_still_wait_offset_calibrator: writes registers and streams
// sample items through several calibration scenarios, then reports the verdict.
// Depends on iswoc_pkg, the calibrator RTL and offset_calib_checker.
module tb;
	import iswoc_pkg::*;

	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;

	typedef logic [AXES-1:0][SAMPLE_BITS-1:0] axes_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	axes_t       raw = '0;
	logic        out_ready = 1'b0;

	logic        cfg_ready;
	logic        in_ready;
	logic        out_valid;
	logic [15:0] accel_x_out, accel_y_out, accel_z_out;
	logic [15:0] gyro_x_out, gyro_y_out, gyro_z_out;
	logic [1:0]  calib_phase;
	logic        calibrated;

	int          mismatches;
	int          outstanding;
	int          sent = 0;
	int          send_idle = 0;
	int          recv_idle = 0;
	int          cycles = 0;
	axes_t       last_sent = '0;

	imu_still_wait_offset_calibrator uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.accel_x_raw (raw[0]),
		.accel_y_raw (raw[1]),
		.accel_z_raw (raw[2]),
		.gyro_x_raw  (raw[3]),
		.gyro_y_raw  (raw[4]),
		.gyro_z_raw  (raw[5]),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.accel_x_out (accel_x_out),
		.accel_y_out (accel_y_out),
		.accel_z_out (accel_z_out),
		.gyro_x_out  (gyro_x_out),
		.gyro_y_out  (gyro_y_out),
		.gyro_z_out  (gyro_z_out),
		.calib_phase (calib_phase),
		.calibrated  (calibrated)
	);

	offset_calib_checker calib_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.accel_x_raw (raw[0]),
		.accel_y_raw (raw[1]),
		.accel_z_raw (raw[2]),
		.gyro_x_raw  (raw[3]),
		.gyro_y_raw  (raw[4]),
		.gyro_z_raw  (raw[5]),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.accel_x_out (accel_x_out),
		.accel_y_out (accel_y_out),
		.accel_z_out (accel_z_out),
		.gyro_x_out  (gyro_x_out),
		.gyro_y_out  (gyro_y_out),
		.gyro_z_out  (gyro_z_out),
		.calib_phase (calib_phase),
		.calibrated  (calibrated),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #4 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("imu_still_wait_offset_calibrator verification failed");
			$finish;
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	function automatic axes_t rand_sample();
		return {$urandom(), $urandom(), $urandom()};
	endfunction

	// one register write, held until the handshake
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// one sample item, with a random gap ahead of it
	task automatic send_sample(input axes_t smp);
		send_idle = (sent < 170) ? 12 : (sent < 340) ? 63 : 0;
		recv_idle <= (sent < 170) ? 63 : (sent < 340) ? 12 : 0;
		if ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		raw <= smp;
		do @(posedge clk); while (!in_ready);
		last_sent = smp;
		sent++;
	endtask

	// accel moves by less than the threshold on every axis
	task automatic send_still(input int thr_v);
		axes_t smp;
		int    a;
		smp = rand_sample();
		for (int i = 0; i < ACCEL_AXES; i++) begin
			a = $signed(last_sent[i]) + int'($urandom_range(0, 2 * thr_v - 2)) - thr_v + 1;
			if (a > 32767)
				a = 32767;
			if (a < -32768)
				a = -32768;
			smp[i] = 16'(a);
		end
		send_sample(smp);
	endtask

	// accel x jumps by half the range, breaking any still run
	task automatic send_jump();
		axes_t smp;
		smp = rand_sample();
		smp[0] = last_sent[0] ^ 16'h8000;
		send_sample(smp);
	endtask

	// wait for every result, then let the pipeline drain
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		axes_t smp;
		int    r_len;
		int    thr_v;
		int    grav_v;
		int    n;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// priming sample, field extremes and bit patterns under reset settings
		send_sample('0);
		send_sample({AXES{16'h7fff}});
		send_sample({AXES{16'h8000}});
		send_sample({AXES{16'h5555}});
		send_sample({AXES{16'haaaa}});
		// deltas just under and at the threshold, both directions
		smp = {AXES{16'd1000}};
		send_sample(smp);
		smp[0] = 16'd1399;
		send_sample(smp);
		smp[1] = 16'd601;
		send_sample(smp);
		send_sample(smp);
		smp[2] = 16'd1400;
		send_sample(smp);
		smp[0] = 16'd999;
		send_sample(smp);
		send_sample(smp);

		// zero threshold: nothing is ever still, even repeated samples
		settle();
		write_reg(REG_STILL_THRESHOLD, 16'd0);
		write_reg(REG_STILL_RUN_LENGTH, {8'($urandom), 8'd1});
		write_reg(REG_GRAVITY_REF, 16'h7fff);
		write_reg(REG_UNUSED, 16'($urandom));
		repeat (60) begin
			if ($urandom_range(0, 1) != 0)
				send_sample(last_sent);
			else
				send_sample(rand_sample());
		end

		// widest threshold, longest run; full-swing pairs keep the run short
		settle();
		write_reg(REG_STILL_THRESHOLD, 16'hffff);
		write_reg(REG_STILL_RUN_LENGTH, {8'($urandom), 8'd255});
		write_reg(REG_GRAVITY_REF, 16'h8000);
		for (n = 0; n < 150; n++) begin
			if (n % 50 == 49) begin
				smp = rand_sample();
				smp[0] = 16'h8000;
				send_sample(smp);
				smp = rand_sample();
				smp[0] = 16'h7fff;
				send_sample(smp);
			end else begin
				send_sample(rand_sample());
			end
		end

		// calibration: noise, broken runs, a full run, averaging, corrected stream
		settle();
		case ($urandom_range(0, 7))
		0: r_len = 0;
		1: r_len = 1;
		2: r_len = 255;
		default: r_len = $urandom_range(2, 40);
		endcase
		thr_v = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 4000);
		case ($urandom_range(0, 2))
		0: grav_v = 0;
		1: grav_v = 32767;
		default: grav_v = $urandom_range(0, 32767);
		endcase
		write_reg(REG_STILL_THRESHOLD, 16'(thr_v));
		write_reg(REG_STILL_RUN_LENGTH, {8'($urandom), 8'(r_len)});
		write_reg(REG_GRAVITY_REF, {1'($urandom), 15'(grav_v)});
		send_jump();
		repeat (12) send_sample(rand_sample());
		if (r_len > 1) begin
			n = (r_len < 30) ? r_len - 1 : 29;
			repeat (3) begin
				send_jump();
				repeat ($urandom_range(1, n)) send_still(thr_v);
			end
		end
		send_jump();
		repeat (r_len + 3) send_still(thr_v);
		repeat (AVG_SAMPLES + 5) send_sample(rand_sample());
		// corrected outputs wrap at the extremes
		send_sample({AXES{16'h7fff}});
		send_sample({AXES{16'h8000}});
		repeat (120) begin
			if ($urandom_range(0, 4) == 0)
				send_sample(last_sent);
			else
				send_sample(rand_sample());
		end

		settle();
		if (mismatches == 0)
			$display("imu_still_wait_offset_calibrator verification clean");
		else
			$display("imu_still_wait_offset_calibrator verification failed");
		$finish;
	end

endmodule
